// ----- rtl/bswc_pkg.sv -----
// Shared types and fixed widths for the bubble sort core with counts.
// Depends on nothing; used by bubble_sort_with_counts_core.
package bswc_pkg;

    // Key word width, signed two's complement
    localparam int KEY_W      = 16;
    // Width of the position field and the result limit that follows from it
    localparam int POS_W      = 5;
    localparam int RESULT_MAX = 32;
    // Width of the comparison and swap counters
    localparam int COUNT_W    = 9;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SORT  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

// ----- rtl/bubble_sort_with_counts_core.sv -----
// Top level of the bubble sort core: key store in one synchronous RAM,
// load / sort / emit sequencer, and the result output register.
// Depends on bswc_pkg.

// Keys are loaded one word per cycle into an internal RAM of
// min(CAPACITY, 32) entries until a word with s_final_element set arrives;
// keys beyond that depth are dropped and flag m_overflowed. The stored n keys
// are then bubble sorted in place: each pass streams the RAM through one read
// port and one write port, carrying the larger key forward and writing the
// smaller one back behind the read pointer. Results then leave lowest key
// first; each word is read from the RAM into the single output register,
// and the next word is fetched only after that one has been loaded and the
// register will be free. s_ready is low from the final word until the last
// result word has been taken. Every result word of a run carries the same
// comparison count, swap count and overflow flag.
module bubble_sort_with_counts_core #(
    parameter int CAPACITY = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [bswc_pkg::KEY_W-1:0]  s_key,
    input  logic                               s_final_element,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bswc_pkg::KEY_W-1:0]  m_sorted_key,
    output logic [bswc_pkg::POS_W-1:0]         m_position,
    output logic                               m_end_of_run,
    output logic [bswc_pkg::COUNT_W-1:0]       m_compare_count,
    output logic [bswc_pkg::COUNT_W-1:0]       m_swap_count,
    output logic                               m_overflowed
);

    localparam int LIMIT  = (CAPACITY < bswc_pkg::RESULT_MAX) ? CAPACITY
                                                               : bswc_pkg::RESULT_MAX;
    localparam int ADDR_W = $clog2(LIMIT);
    localparam int CNT_W  = $clog2(LIMIT + 1);

    // Key store
    logic signed [bswc_pkg::KEY_W-1:0] mem [LIMIT];
    logic signed [bswc_pkg::KEY_W-1:0] rdata_reg;

    logic                              wr_en;
    logic [ADDR_W-1:0]                 wr_addr;
    logic signed [bswc_pkg::KEY_W-1:0] wr_data;
    logic                              rd_en;
    logic [ADDR_W-1:0]                 rd_addr;

    // Control and counters
    bswc_pkg::state_t                  st_reg, st_next;
    logic [CNT_W-1:0]                  fill_reg, fill_next;
    logic                              ovf_reg, ovf_next;
    logic [bswc_pkg::COUNT_W-1:0]      swap_reg, swap_next;
    logic [bswc_pkg::COUNT_W-1:0]      cmp_reg, cmp_next;
    logic [ADDR_W-1:0]                 last_reg, last_next;
    logic [CNT_W-1:0]                  rdk_reg, rdk_next;
    logic                              rv_reg, rv_next;
    logic [ADDR_W-1:0]                 ridx_reg, ridx_next;
    logic signed [bswc_pkg::KEY_W-1:0] carry_reg, carry_next;
    logic [CNT_W-1:0]                  emit_reg, emit_next;
    logic                              pend_reg, pend_next;
    logic                              mv_reg, mv_next;

    // Result payload
    logic signed [bswc_pkg::KEY_W-1:0] okey_reg, okey_next;
    logic [bswc_pkg::POS_W-1:0]        opos_reg, opos_next;
    logic                              oend_reg, oend_next;

    logic [CNT_W-1:0]                  n_load;

    assign s_ready         = (st_reg == bswc_pkg::ST_LOAD);
    assign m_valid         = mv_reg;
    assign m_sorted_key    = okey_reg;
    assign m_position      = opos_reg;
    assign m_end_of_run    = oend_reg;
    assign m_compare_count = cmp_reg;
    assign m_swap_count    = swap_reg;
    assign m_overflowed    = ovf_reg;

    // Sequencer and RAM port control
    always_comb begin
        st_next    = st_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        swap_next  = swap_reg;
        cmp_next   = cmp_reg;
        last_next  = last_reg;
        rdk_next   = rdk_reg;
        rv_next    = 1'b0;
        ridx_next  = ridx_reg;
        carry_next = carry_reg;
        emit_next  = emit_reg;
        pend_next  = pend_reg;
        mv_next    = mv_reg;
        okey_next  = okey_reg;
        opos_next  = opos_reg;
        oend_next  = oend_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = s_key;
        rd_en      = 1'b0;
        rd_addr    = '0;
        n_load     = fill_reg;

        unique case (st_reg)
            bswc_pkg::ST_LOAD: begin
                if (s_valid) begin
                    // store the word if there is room, else drop it
                    if (fill_reg < CNT_W'(LIMIT)) begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[ADDR_W-1:0];
                        n_load    = fill_reg + 1'b1;
                        fill_next = n_load;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_final_element) begin
                        cmp_next  = '0;
                        swap_next = '0;
                        rdk_next  = '0;
                        emit_next = '0;
                        pend_next = 1'b0;
                        last_next = ADDR_W'(n_load - 1'b1);
                        if (n_load == CNT_W'(1)) begin
                            st_next = bswc_pkg::ST_EMIT;
                        end else begin
                            st_next = bswc_pkg::ST_SORT;
                        end
                    end
                end
            end

            bswc_pkg::ST_SORT: begin
                // stream reads ahead of the write-back pointer
                if (rdk_reg <= CNT_W'(last_reg)) begin
                    rd_en     = 1'b1;
                    rd_addr   = rdk_reg[ADDR_W-1:0];
                    rdk_next  = rdk_reg + 1'b1;
                    rv_next   = 1'b1;
                    ridx_next = rdk_reg[ADDR_W-1:0];
                end
                // compare carried key with the key just read
                if (rv_reg) begin
                    if (ridx_reg == '0) begin
                        carry_next = rdata_reg;
                    end else begin
                        cmp_next = cmp_reg + 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = ridx_reg - 1'b1;
                        if (carry_reg > rdata_reg) begin
                            wr_data   = rdata_reg;
                            swap_next = swap_reg + 1'b1;
                        end else begin
                            wr_data    = carry_reg;
                            carry_next = rdata_reg;
                        end
                    end
                    if (ridx_reg == last_reg) begin
                        st_next = bswc_pkg::ST_FLUSH;
                    end
                end
            end

            bswc_pkg::ST_FLUSH: begin
                // write the largest key of the pass to its final place
                wr_en    = 1'b1;
                wr_addr  = last_reg;
                wr_data  = carry_reg;
                rdk_next = '0;
                if (last_reg == ADDR_W'(1)) begin
                    st_next = bswc_pkg::ST_EMIT;
                end else begin
                    last_next = last_reg - 1'b1;
                    st_next   = bswc_pkg::ST_SORT;
                end
            end

            bswc_pkg::ST_EMIT: begin
                // drop the result word once taken; finish the run on the last
                if (mv_reg && m_ready) begin
                    mv_next = 1'b0;
                    if (oend_reg) begin
                        fill_next = '0;
                        swap_next = '0;
                        ovf_next  = 1'b0;
                        st_next   = bswc_pkg::ST_LOAD;
                    end
                end
                // fetch the next key when the output register will be free
                if ((emit_reg < fill_reg) && !pend_reg && (!mv_reg || m_ready)) begin
                    rd_en     = 1'b1;
                    rd_addr   = emit_reg[ADDR_W-1:0];
                    emit_next = emit_reg + 1'b1;
                    pend_next = 1'b1;
                end
                // load the fetched key into the output register
                if (pend_reg) begin
                    okey_next = rdata_reg;
                    opos_next = bswc_pkg::POS_W'(emit_reg - 1'b1);
                    oend_next = (emit_reg == fill_reg);
                    mv_next   = 1'b1;
                    pend_next = 1'b0;
                end
            end

            default: begin
                st_next = bswc_pkg::ST_LOAD;
            end
        endcase
    end

    // Key store RAM, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= bswc_pkg::ST_LOAD;
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
            swap_reg <= '0;
            cmp_reg  <= '0;
            rv_reg   <= 1'b0;
            pend_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            swap_reg <= swap_next;
            cmp_reg  <= cmp_next;
            rv_reg   <= rv_next;
            pend_reg <= pend_next;
            mv_reg   <= mv_next;
        end
    end

    // Pointers and payload registers
    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        rdk_reg   <= rdk_next;
        ridx_reg  <= ridx_next;
        carry_reg <= carry_next;
        emit_reg  <= emit_next;
        okey_reg  <= okey_next;
        opos_reg  <= opos_next;
        oend_reg  <= oend_next;
    end

    // Input is never taken while a result word is pending
    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result word is pending");

    // Last result word taken reopens the input
    a_reopen_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_run) |=> s_ready)
        else $error("input not reopened after end of run");

    // Swaps never outnumber comparisons
    a_swaps_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_swap_count <= m_compare_count))
        else $error("swap count exceeds compare count");

    // Result positions stay inside the stored set
    a_position_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CNT_W'(m_position) < fill_reg))
        else $error("result position beyond stored keys");

    // Sort write-back stays behind the read stream
    a_write_behind_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("RAM read and write hit the same entry");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bubble_sort_with_counts_core; depends on bswc_pkg and the core.
// Directed, full, overflow and random runs; each word checked by an in-bench sort predictor.
module testbench;

    localparam int CAPACITY = 32;
    localparam int LIMIT    = (CAPACITY < bswc_pkg::RESULT_MAX) ? CAPACITY
                                                                 : bswc_pkg::RESULT_MAX;

    // Key patterns for a run
    localparam int SHAPE_RANDOM  = 0;
    localparam int SHAPE_NARROW  = 1;
    localparam int SHAPE_FALLING = 2;

    // One sorted output word
    typedef struct packed {
        logic signed [bswc_pkg::KEY_W-1:0] sorted_key;
        logic [bswc_pkg::POS_W-1:0]        position;
        logic                              end_of_run;
        logic [bswc_pkg::COUNT_W-1:0]      compare_count;
        logic [bswc_pkg::COUNT_W-1:0]      swap_count;
        logic                              overflowed;
    } sorted_word_t;

    // One directed row; the typed fields apply only to single-key runs
    typedef struct packed {
        logic signed [bswc_pkg::KEY_W-1:0] key;
        logic                              is_last;
        logic                              typed;
        logic signed [bswc_pkg::KEY_W-1:0] exp_key;
        logic [bswc_pkg::COUNT_W-1:0]      exp_compares;
        logic [bswc_pkg::COUNT_W-1:0]      exp_swaps;
        logic                              exp_overflow;
    } stim_row_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [bswc_pkg::KEY_W-1:0]  s_key;
    logic                               s_final_element;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [bswc_pkg::KEY_W-1:0]  m_sorted_key;
    logic [bswc_pkg::POS_W-1:0]         m_position;
    logic                               m_end_of_run;
    logic [bswc_pkg::COUNT_W-1:0]       m_compare_count;
    logic [bswc_pkg::COUNT_W-1:0]       m_swap_count;
    logic                               m_overflowed;

    // Predictor state: keys of the run being loaded
    logic signed [bswc_pkg::KEY_W-1:0]  run_keys [LIMIT];
    int                                 run_fill    = 0;
    logic                               run_dropped = 1'b0;

    sorted_word_t                       sorted_words_due [$];
    int                                 mismatch_count = 0;
    int                                 words_taken    = 0;
    int                                 burst_left     = 0;

    // Extremes, single-key runs after reset, a reverse-ordered run, duplicates, a pair
    stim_row_t directed_rows [14] = '{
        '{16'sh0000, 1'b1, 1'b1, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'sh8000, 1'b1, 1'b1, 16'sh8000, 9'd0, 9'd0, 1'b0},
        '{16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 9'd0, 9'd0, 1'b0},
        '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'sh0064, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'sh0000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'shFFFF, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'sh8000, 1'b1, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'shFFFB, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'shFFFB, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'sh0003, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'sh0003, 1'b1, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'sh0001, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0},
        '{16'shFFFF, 1'b1, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0}
    };

    bubble_sort_with_counts_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key           (s_key),
        .s_final_element (s_final_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sorted_key    (m_sorted_key),
        .m_position      (m_position),
        .m_end_of_run    (m_end_of_run),
        .m_compare_count (m_compare_count),
        .m_swap_count    (m_swap_count),
        .m_overflowed    (m_overflowed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Store one key; on the closing word, bubble sort the run and queue its sorted words
    function automatic int absorb_key(input logic signed [bswc_pkg::KEY_W-1:0] k,
                                      input logic is_last);
        int                                n;
        int                                compares;
        int                                swaps;
        logic signed [bswc_pkg::KEY_W-1:0] held;
        sorted_word_t                      w;
        if (run_fill < LIMIT) begin
            run_keys[run_fill] = k;
            run_fill++;
        end else begin
            run_dropped = 1'b1;
        end
        if (!is_last) return 0;
        n        = run_fill;
        compares = 0;
        swaps    = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j + 1 + i < n; j++) begin
                compares++;
                if (run_keys[j] > run_keys[j+1]) begin
                    held          = run_keys[j];
                    run_keys[j]   = run_keys[j+1];
                    run_keys[j+1] = held;
                    swaps++;
                end
            end
        end
        for (int p = 0; p < n; p++) begin
            w.sorted_key    = run_keys[p];
            w.position      = bswc_pkg::POS_W'(p);
            w.end_of_run    = (p + 1 == n);
            w.compare_count = bswc_pkg::COUNT_W'(compares);
            w.swap_count    = bswc_pkg::COUNT_W'(swaps);
            w.overflowed    = run_dropped;
            sorted_words_due.push_back(w);
        end
        run_fill    = 0;
        run_dropped = 1'b0;
        return n;
    endfunction

    function automatic void report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    // Offer one key word in bursts with random gaps; predict on acceptance
    task automatic offer_key(input logic signed [bswc_pkg::KEY_W-1:0] k, input logic is_last,
                             output int words_new);
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end else begin
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_key           <= k;
        s_final_element <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        words_new = absorb_key(k, is_last);
    endtask

    // Hold off the sender until every due word has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sorted_words_due.size() != 0) @(posedge aclk);
    endtask

    // Send one run of run_len keys in the given key pattern
    task automatic send_run(input int run_len, input int shape);
        logic signed [bswc_pkg::KEY_W-1:0] k;
        int                                v;
        int                                words_new;
        for (int i = 0; i < run_len; i++) begin
            case (shape)
                SHAPE_RANDOM: k = bswc_pkg::KEY_W'($urandom_range(0, 65535));
                SHAPE_NARROW: begin
                    v = $urandom_range(0, 6) - 3;
                    k = bswc_pkg::KEY_W'(v);
                end
                default: k = bswc_pkg::KEY_W'(32767 - i * 2000);
            endcase
            offer_key(k, i == run_len - 1, words_new);
        end
    endtask

    // Stimulus: reset, directed table, forced full and overflowing runs, random runs
    initial begin
        sorted_word_t w;
        int           words_new;
        int           items_sent;
        int           run_len;
        int           pick;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_key           = '0;
        s_final_element = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[r]) begin
            offer_key(directed_rows[r].key, directed_rows[r].is_last, words_new);
            if (directed_rows[r].typed && words_new == 1) begin
                void'(sorted_words_due.pop_back());
                w.sorted_key    = directed_rows[r].exp_key;
                w.position      = '0;
                w.end_of_run    = 1'b1;
                w.compare_count = directed_rows[r].exp_compares;
                w.swap_count    = directed_rows[r].exp_swaps;
                w.overflowed    = directed_rows[r].exp_overflow;
                sorted_words_due.push_back(w);
            end
        end
        wait_drained();

        // Full store in reverse order, then a run that overflows, final word included
        send_run(LIMIT, SHAPE_FALLING);
        send_run(LIMIT + 4, SHAPE_RANDOM);
        items_sent = 2 * LIMIT + 4;

        // Random runs, mostly short
        while (items_sent < 210) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      run_len = $urandom_range(LIMIT + 1, LIMIT + 8);
            else if (pick < 4)  run_len = $urandom_range(9, LIMIT);
            else                run_len = $urandom_range(1, 8);
            send_run(run_len, ($urandom_range(0, 3) == 0) ? SHAPE_NARROW : SHAPE_RANDOM);
            items_sent += run_len;
        end

        wait_drained();
        repeat (700) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off once the first runs are out
    initial begin
        sorted_word_t exp_w;
        sorted_word_t got_w;
        int           ready_left;
        int           stall_left;
        bit           long_hold_done;
        m_ready        = 1'b0;
        ready_left     = 0;
        stall_left     = 0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && words_taken >= 24) begin
                long_hold_done = 1'b1;
                stall_left     = 400;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (ready_left > 0) begin
                    ready_left--;
                end else begin
                    ready_left = $urandom_range(0, 30);
                    stall_left = $urandom_range(0, 5);
                end
            end
            @(posedge aclk);
            // Compare each taken word with the oldest due word
            if (aresetn && m_valid && m_ready) begin
                got_w.sorted_key    = m_sorted_key;
                got_w.position      = m_position;
                got_w.end_of_run    = m_end_of_run;
                got_w.compare_count = m_compare_count;
                got_w.swap_count    = m_swap_count;
                got_w.overflowed    = m_overflowed;
                if (sorted_words_due.size() == 0) begin
                    report_mismatch($sformatf("word %0d with nothing due: key %0d pos %0d",
                                              words_taken, got_w.sorted_key, got_w.position));
                end else begin
                    exp_w = sorted_words_due.pop_front();
                    if (got_w.sorted_key !== exp_w.sorted_key ||
                        got_w.position !== exp_w.position ||
                        got_w.end_of_run !== exp_w.end_of_run ||
                        got_w.compare_count !== exp_w.compare_count ||
                        got_w.swap_count !== exp_w.swap_count ||
                        got_w.overflowed !== exp_w.overflowed) begin
                        report_mismatch($sformatf(
                            "word %0d: expected key %0d pos %0d end %0b cmp %0d swp %0d ovf %0b, %s",
                            words_taken, exp_w.sorted_key, exp_w.position, exp_w.end_of_run,
                            exp_w.compare_count, exp_w.swap_count, exp_w.overflowed,
                            $sformatf("got key %0d pos %0d end %0b cmp %0d swp %0d ovf %0b",
                                      got_w.sorted_key, got_w.position, got_w.end_of_run,
                                      got_w.compare_count, got_w.swap_count,
                                      got_w.overflowed)));
                    end
                end
                words_taken++;
            end
        end
    end

    // Watchdog: the slowest correct run is far below this
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bswc_pkg.sv
rtl/bubble_sort_with_counts_core.sv
tb/sv/testbench.sv
